// ----- rtl/core/us2cal_pkg.sv -----
// ----------------------------------------------------------------------------
// us2cal_pkg
// Types, constants and per-stage arithmetic for the seconds-to-calendar pipe.
// ----------------------------------------------------------------------------
package us2cal_pkg;

    localparam int unsigned NUM_STAGES = 11;
    localparam int unsigned LAST_STAGE = NUM_STAGES - 1;

    localparam int unsigned STG_INPUT    = 0;
    localparam int unsigned STG_RANGE    = 1;
    localparam int unsigned STG_DAYS_EST = 2;
    localparam int unsigned STG_DAYS     = 3;
    localparam int unsigned STG_ERA_EST  = 4;
    localparam int unsigned STG_ERA      = 5;
    localparam int unsigned STG_CENT     = 6;
    localparam int unsigned STG_YOE      = 7;
    localparam int unsigned STG_DOY      = 8;
    localparam int unsigned STG_MP       = 9;
    localparam int unsigned STG_FINAL    = 10;

    localparam int unsigned IN_WIDTH = 39;

    localparam logic signed [IN_WIDTH-1:0] FIRST_INSTANT = -39'sd62135596800;
    localparam logic signed [IN_WIDTH-1:0] LAST_INSTANT  = 39'sd253402300799;

    // 86400 = 128 * 675
    localparam logic [31:0] DAY_ODD_DIV   = 32'd675;
    localparam logic [31:0] RECIP_675     = 32'd3257812230;
    localparam logic [21:0] Z_OFFSET      = 22'd306;
    localparam logic [21:0] DAYS_PER_ERA  = 22'd146097;
    localparam logic [22:0] RECIP_ERA     = 23'd7525901;
    localparam logic [17:0] DIV60_M       = 18'd139811;
    localparam logic [13:0] DIV60_SMALL_M = 14'd8739;
    localparam logic [15:0] DIV365_M      = 16'd45965;
    localparam logic [12:0] DIV153_M      = 13'd6854;
    localparam logic [17:0] DOE_4YR_1     = 18'd36524;
    localparam logic [17:0] DOE_4YR_2     = 18'd73048;
    localparam logic [17:0] DOE_4YR_3     = 18'd109572;
    localparam logic [17:0] DOE_LAST      = 18'd146096;
    localparam logic [13:0] YEARS_PER_ERA = 14'd400;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] s;
        logic                       oor;
        logic [IN_WIDTH-1:0]        u;
        logic [21:0]                q_est;
        logic [21:0]                z;
        logic [16:0]                tod;
        logic [10:0]                mins;
        logic [4:0]                 era;
        logic [17:0]                doe;
        logic [5:0]                 sec;
        logic [4:0]                 hour;
        logic [5:0]                 minute;
        logic [6:0]                 a;
        logic [2:0]                 b;
        logic                       c;
        logic [8:0]                 yoe;
        logic [8:0]                 doy;
        logic [3:0]                 mp;
        logic [13:0]                year;
        logic [3:0]                 month;
        logic [4:0]                 day;
    } work_t;

    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic work_t load_input(input logic [IN_WIDTH-1:0] raw);
        work_t r;
        r   = '0;
        r.s = signed'(raw);
        return r;
    endfunction

    function automatic work_t stage_calc(input int unsigned stage, input work_t w);
        work_t       r;
        logic [31:0] q1;
        logic [63:0] p_day;
        logic [31:0] p_rem;
        logic [31:0] rem;
        logic        fix;
        logic [9:0]  r_day;
        logic [21:0] days;
        logic [44:0] p_era;
        logic [34:0] p_min;
        logic [21:0] era_days;
        logic [21:0] doe_raw;
        logic [16:0] sec_full;
        logic [24:0] p_hour;
        logic [31:0] p_a;
        logic [10:0] min_full;
        logic [17:0] t;
        logic [33:0] p_yoe;
        logic [1:0]  cent;
        logic [17:0] sub;
        logic [17:0] doy_full;
        logic [10:0] num;
        logic [23:0] p_mp;
        logic [3:0]  mon;
        logic [8:0]  dom;
        logic [13:0] yr;
        r = w;
        case (stage)
            STG_RANGE:
            begin
                r.oor = (w.s < FIRST_INSTANT) || (w.s > LAST_INSTANT);
                r.u   = unsigned'(w.s - FIRST_INSTANT);
            end
            STG_DAYS_EST:
            begin
                q1      = w.u[IN_WIDTH-1:7];
                p_day   = 64'(q1) * 64'(RECIP_675);
                r.q_est = p_day[62:41];
            end
            STG_DAYS:
            begin
                q1    = w.u[IN_WIDTH-1:7];
                p_rem = 32'(w.q_est) * DAY_ODD_DIV;
                rem   = q1 - p_rem;
                fix   = rem >= DAY_ODD_DIV;
                r_day = fix ? 10'(rem - DAY_ODD_DIV) : rem[9:0];
                days  = w.q_est + 22'(fix);
                r.z   = days + Z_OFFSET;
                r.tod = {r_day, w.u[6:0]};
            end
            STG_ERA_EST:
            begin
                p_era  = 45'(w.z) * 45'(RECIP_ERA);
                r.era  = p_era[44:40];
                p_min  = 35'(w.tod) * 35'(DIV60_M);
                r.mins = p_min[33:23];
            end
            STG_ERA:
            begin
                era_days = 22'(w.era) * DAYS_PER_ERA;
                doe_raw  = w.z - era_days;
                fix      = doe_raw >= DAYS_PER_ERA;
                r.doe    = fix ? 18'(doe_raw - DAYS_PER_ERA) : doe_raw[17:0];
                r.era    = w.era + 5'(fix);
                sec_full = w.tod - 17'(w.mins) * 17'd60;
                r.sec    = sec_full[5:0];
                p_hour   = 25'(w.mins) * 25'(DIV60_SMALL_M);
                r.hour   = p_hour[23:19];
            end
            STG_CENT:
            begin
                p_a      = 32'(w.doe[17:2]) * 32'(DIV365_M);
                r.a      = p_a[30:24];
                r.b      = 3'(w.doe >= DOE_4YR_1) + 3'(w.doe >= DOE_4YR_2)
                         + 3'(w.doe >= DOE_4YR_3) + 3'(w.doe >= DOE_LAST);
                r.c      = w.doe == DOE_LAST;
                min_full = w.mins - 11'(w.hour) * 11'd60;
                r.minute = min_full[5:0];
            end
            STG_YOE:
            begin
                t     = w.doe - 18'(w.a) + 18'(w.b) - 18'(w.c);
                p_yoe = 34'(t) * 34'(DIV365_M);
                r.yoe = p_yoe[32:24];
            end
            STG_DOY:
            begin
                cent     = 2'(w.yoe >= 9'd100) + 2'(w.yoe >= 9'd200) + 2'(w.yoe >= 9'd300);
                sub      = 18'(w.yoe) * 18'd365 + 18'(w.yoe[8:2]) - 18'(cent);
                doy_full = w.doe - sub;
                r.doy    = doy_full[8:0];
            end
            STG_MP:
            begin
                num  = 11'(w.doy) * 11'd5 + 11'd2;
                p_mp = 24'(num) * 24'(DIV153_M);
                r.mp = p_mp[23:20];
            end
            STG_FINAL:
            begin
                mon = (w.mp < 4'd10) ? w.mp + 4'd3 : w.mp - 4'd9;
                dom = w.doy - month_start(w.mp) + 9'd1;
                yr  = 14'(w.yoe) + 14'(w.era) * YEARS_PER_ERA + 14'(mon <= 4'd2);
                if (w.oor)
                begin
                    r.year   = '0;
                    r.month  = '0;
                    r.day    = '0;
                    r.hour   = '0;
                    r.minute = '0;
                    r.sec    = '0;
                end
                else
                begin
                    r.year  = yr;
                    r.month = mon;
                    r.day   = dom[4:0];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/unix_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Signed Unix seconds to proleptic Gregorian UTC date and time of day.
// ----------------------------------------------------------------------------
// One timestamp enters per cycle unless the input is stalled, and its date comes
// out of the last stage of the arithmetic pipeline (at most one constant
// multiplier and a few adders deep in any stage).
// Each stage holds its item independently, so a stalled output only stops the
// stages behind it once they are full; the input stalls only while the output
// is held and every stage holds an item. Instants before year 1 or after year
// 9999 come out with tuser set and all date and time fields zero.
module unix_seconds_to_calendar
    import us2cal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // epoch_seconds[38:0], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // year, month, day_of_month, hour, minute, second
    output logic        m_axis_tuser    // out_of_range
);

    work_t                 work_reg  [NUM_STAGES];
    work_t                 work_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] advance;

    assign work_next[STG_INPUT] = load_input(s_axis_tdata[IN_WIDTH-1:0]);

    for (genvar i = 1; i < NUM_STAGES; i++)
    begin : g_stage
        assign work_next[i] = stage_calc(i, work_reg[i-1]);
    end

    // a stage moves when it is empty or the one after it moves
    assign advance[LAST_STAGE] = !valid_reg[LAST_STAGE] || m_axis_tready;
    for (genvar i = 0; i < LAST_STAGE; i++)
    begin : g_advance
        assign advance[i] = !valid_reg[i] || advance[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (advance[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (advance[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (advance[i])
            begin
                work_reg[i] <= work_next[i];
            end
        end
    end

    assign s_axis_tready = advance[0];
    assign m_axis_tvalid = valid_reg[LAST_STAGE];
    assign m_axis_tdata  = {work_reg[LAST_STAGE].sec,
                            work_reg[LAST_STAGE].minute,
                            work_reg[LAST_STAGE].hour,
                            work_reg[LAST_STAGE].day,
                            work_reg[LAST_STAGE].month,
                            work_reg[LAST_STAGE].year};
    assign m_axis_tuser  = work_reg[LAST_STAGE].oor;

endmodule

// ----- rtl/core/us2cal_checker.sv -----
// ----------------------------------------------------------------------------
// us2cal_checker
// Port-level checks for the seconds-to-calendar block.
// ----------------------------------------------------------------------------
module us2cal_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    assign year   = m_axis_tdata[13:0];
    assign month  = m_axis_tdata[17:14];
    assign day    = m_axis_tdata[22:18];
    assign hour   = m_axis_tdata[27:23];
    assign minute = m_axis_tdata[33:28];
    assign second = m_axis_tdata[39:34];

    // out of range items carry no date
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
        else $error("out of range item with nonzero fields");

    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            year >= 14'd1 && year <= 14'd9999 && month >= 4'd1 && month <= 4'd12
            && day >= 5'd1 && day <= 5'd31 && hour <= 5'd23
            && minute <= 6'd59 && second <= 6'd59)
        else $error("date or time field out of its range");

    // input stalls only under output backpressure
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output item changed");

endmodule

bind unix_seconds_to_calendar us2cal_checker u_us2cal_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/unix_seconds_to_calendar_test.sv -----
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_test
// Sends signed Unix timestamps through the stream input and checks every date
// against an in-bench calendar calculation. It covers the edges of years 1 and
// 9999, day, leap and era boundaries, uniform and raw bit-pattern timestamps,
// random gaps on both sides, full-rate bursts and a long output hold-off.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_test;

    localparam longint EARLIEST     = -64'sd62135596800;
    localparam longint LATEST       = 64'sd253402300799;
    localparam longint SECS_PER_DAY = 86400;
    localparam longint ERA_SECS     = 64'sd146097 * 64'sd86400;
    localparam longint MARCH_2000   = 64'sd951868800;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     IDLE_LIMIT   = 3000;
    localparam int     DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        oor;
    } calendar_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // epoch_seconds[38:0], pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // year, month, day_of_month, hour, minute, second
    logic        m_axis_tuser;         // out_of_range

    calendar_t   expected_dates[$];
    int          mismatch_count = 0;
    bit          full_rate = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    unix_seconds_to_calendar dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic calendar_t calendar_of(input logic [38:0] raw);
        calendar_t r;
        longint    secs;
        longint    days;
        longint    tod;
        longint    z;
        longint    era;
        longint    doe;
        longint    yoe;
        longint    doy;
        longint    mp;
        longint    m;
        r    = '0;
        secs = signed'(raw);
        if (secs < EARLIEST || secs > LATEST)
        begin
            r.oor = 1'b1;
            return r;
        end
        days = secs / SECS_PER_DAY;
        if (secs % SECS_PER_DAY < 0)
        begin
            days = days - 1;
        end
        tod = secs - days * SECS_PER_DAY;
        z   = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        r.year   = 14'(yoe + era * 400 + ((m <= 2) ? 1 : 0));
        r.month  = 4'(m);
        r.day    = 5'(doy - (153 * mp + 2) / 5 + 1);
        r.hour   = 5'(tod / 3600);
        r.minute = 6'((tod / 60) % 60);
        r.second = 6'(tod % 60);
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(3, 1);
        end
        else if (r < 98)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    task automatic send_stamp(input longint stamp);
        int gap;
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, stamp[38:0]};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        expected_dates.push_back(calendar_of(stamp[38:0]));
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_date();
        calendar_t want;
        if (expected_dates.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h/%b",
                     $time, m_axis_tdata, m_axis_tuser);
            mismatch_count++;
            return;
        end
        want = expected_dates.pop_front();
        check_field("year",         want.year,   m_axis_tdata[13:0]);
        check_field("month",        want.month,  m_axis_tdata[17:14]);
        check_field("day_of_month", want.day,    m_axis_tdata[22:18]);
        check_field("hour",         want.hour,   m_axis_tdata[27:23]);
        check_field("minute",       want.minute, m_axis_tdata[33:28]);
        check_field("second",       want.second, m_axis_tdata[39:34]);
        check_field("out_of_range", want.oor,    m_axis_tuser);
    endtask

    // output side: checks results and drives tready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_date();
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (full_rate)
            begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic longint uniform_stamp();
        longint unsigned u;
        u = {$urandom, $urandom};
        return EARLIEST + longint'(u % longint'(LATEST - EARLIEST + 1));
    endfunction

    task automatic test_directed_dates();
        longint stamps[$];
        stamps = '{0, -1, -86400, -86401, EARLIEST, EARLIEST - 1, LATEST, LATEST + 1,
                   -64'sd274877906944, 64'sd274877906943, 64'sd951782400, MARCH_2000,
                   64'sd946684799, -64'sd2203977600, -64'sd2203891200,
                   64'sd1709251199, 64'sd4107542400, 64'sd2147483647,
                   -64'sd2147483648, 64'sd253402214400, -64'sd62135510400,
                   MARCH_2000 - ERA_SECS, MARCH_2000 - ERA_SECS - 1};
        foreach (stamps[i])
        begin
            send_stamp(stamps[i]);
        end
    endtask

    task automatic test_uniform_range(input int count);
        repeat (count)
        begin
            send_stamp(uniform_stamp());
        end
    endtask

    // raw 39-bit patterns, a large share of them out of range
    task automatic test_raw_bit_patterns(input int count);
        longint unsigned u;
        repeat (count)
        begin
            u = {$urandom, $urandom};
            send_stamp(longint'(u));
        end
    endtask

    task automatic test_range_edges(input int count);
        longint base;
        longint k;
        repeat (count)
        begin
            case ($urandom_range(4, 0))
                0: base = EARLIEST;
                1: base = LATEST;
                2: base = 0;
                3:
                begin
                    k    = longint'($urandom_range(3652058, 0)) - 719162;
                    base = k * SECS_PER_DAY;
                end
                default: base = MARCH_2000 + (longint'($urandom_range(9, 0)) - 5) * ERA_SECS;
            endcase
            send_stamp(base + longint'($urandom_range(200, 0)) - 100);
        end
    endtask

    task automatic test_full_rate(input int count);
        full_rate = 1'b1;
        test_uniform_range(count);
        full_rate = 1'b0;
    endtask

    // output held off while the input keeps offering items back to back
    task automatic test_output_hold(input int count);
        hold_request = 1'b1;
        full_rate    = 1'b1;
        repeat (count)
        begin
            send_stamp(uniform_stamp());
        end
        full_rate = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_dates();
        test_uniform_range(800);
        test_raw_bit_patterns(300);
        test_range_edges(250);
        test_full_rate(100);
        test_output_hold(100);
        test_uniform_range(80);
        s_axis_tvalid <= 1'b0;
        wait (expected_dates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
